/* src/abps_pkg.sv */
// Shared types, codes and arithmetic helpers for the alpha blending pixel store.
package abps_pkg;

  // Payload types.
  typedef logic [1:0]  cmd_t;
  typedef logic [7:0]  coord_t;
  typedef logic [31:0] pix_t;
  typedef logic [1:0]  status_t;
  typedef logic [8:0]  dim_t;
  typedef logic [7:0]  offs_t;
  typedef logic [15:0] mix_sum_t;
  typedef logic [7:0]  chan_t;

  // Command codes.
  localparam cmd_t CMD_BLEND = 2'd0;
  localparam cmd_t CMD_RAW   = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;
  localparam cmd_t CMD_BLIT  = 2'd3;

  // Result status codes.
  localparam status_t STAT_WRITTEN = 2'd0;
  localparam status_t STAT_READ    = 2'd1;
  localparam status_t STAT_SKIPPED = 2'd2;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_DEST_WIDTH    = 3'd0,
    CFG_DEST_HEIGHT   = 3'd1,
    CFG_SOURCE_WIDTH  = 3'd2,
    CFG_SOURCE_HEIGHT = 3'd3,
    CFG_X_OFFSET      = 3'd4,
    CFG_Y_OFFSET      = 3'd5,
    CFG_COPY_WIDTH    = 3'd6,
    CFG_COPY_HEIGHT   = 3'd7
  } cfg_idx_t;

  // Register reset values.
  localparam dim_t  DIM_RESET  = 9'd256;
  localparam offs_t OFFS_RESET = 8'd0;

  // Full alpha and the reciprocal of 255 in 2^-23 units (exact for sums below 66052).
  localparam chan_t       ALPHA_FULL = 8'd255;
  localparam logic [15:0] RECIP_255  = 16'd32897;
  localparam int          DIV_SHIFT  = 23;

  // Weighted sum of one channel: new*a + old*(255-a), at most 65025.
  function automatic mix_sum_t mix_sum(chan_t nv, chan_t ov, chan_t a);
    mix_sum_t pn;
    mix_sum_t po;
    pn = mix_sum_t'(nv) * mix_sum_t'(a);
    po = mix_sum_t'(ov) * mix_sum_t'(ALPHA_FULL - a);
    return pn + po;
  endfunction

  // Floor of a weighted sum divided by 255, by reciprocal multiplication.
  function automatic chan_t div255(mix_sum_t s);
    logic [31:0] p;
    p = 32'(s) * 32'(RECIP_255);
    return p[DIV_SHIFT+7:DIV_SHIFT];
  endfunction

endpackage

/* src/abps_ram.sv */
// Generic single-port synchronous RAM with a registered read.
module abps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One access per cycle: a write, or a read that lands in the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wr_data;
      end else begin
        rd_data_r <= mem[addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/alpha_blend_pixel_store.sv */
// Top level of the alpha blending pixel store: control, address path, blend and frame RAM.
//
//  Channel | Direction | Handshake               | Beat contents
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | in_valid / in_ready     | in_cmd, in_x_coord, in_y_coord, in_color
//  out     | output    | out_valid / out_ready   | out_pixel_value, out_status
//  cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item is in flight at a time. A read adds a RAM read wait to a raw write or skip;
// a blend or blit adds divide and write-back too, set by the read-modify-write via the
// single frame RAM port and the two-step blend (weighted sums, then division by 255).
// Reset is synchronous and clears control and configuration; the frame store is not
// cleared and holds nothing defined until written. A stalled output register holds
// its beat while the next item is already taken in; a second result waits for it.
module alpha_blend_pixel_store #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  // Item input
  input  logic                in_valid,
  output logic                in_ready,
  input  abps_pkg::cmd_t      in_cmd,
  input  abps_pkg::coord_t    in_x_coord,
  input  abps_pkg::coord_t    in_y_coord,
  input  abps_pkg::pix_t      in_color,
  // Result output
  output logic                out_valid,
  input  logic                out_ready,
  output abps_pkg::pix_t      out_pixel_value,
  output abps_pkg::status_t   out_status,
  // Configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  abps_pkg::cfg_idx_t  cfg_index,
  input  abps_pkg::dim_t      cfg_data
);

  import abps_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int          AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int          LIN_W       = 18;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MUL    = 8'b0000_0010,
    ST_ADDR   = 8'b0000_0100,
    ST_ACCESS = 8'b0000_1000,
    ST_RDWAIT = 8'b0001_0000,
    ST_DIV    = 8'b0010_0000,
    ST_WRITE  = 8'b0100_0000,
    ST_RESP   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  dim_t  dest_width_r, dest_height_r, source_width_r, source_height_r;
  dim_t  copy_width_r, copy_height_r;
  offs_t x_offset_r, y_offset_r;

  // Item registers.
  cmd_t             cmd_r;
  pix_t             color_r;
  dim_t             xd_r, yd_r;
  logic             ok_r;
  logic [LIN_W-1:0] prod_r;
  logic [AW-1:0]    addr_r;
  logic             hit_r;
  mix_sum_t         sum_r [3];
  pix_t             pix_r;
  pix_t             res_pix_r;
  status_t          res_status_r;

  // Output register.
  logic    out_valid_r;
  pix_t    out_pixel_r;
  status_t out_status_r;

  // RAM port.
  logic ram_en, ram_we;
  pix_t ram_wdata, ram_rdata;

  logic             in_fire, resp_go;
  logic             src_ok;
  dim_t             x_ext, y_ext;
  logic [LIN_W-1:0] lin_addr;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign resp_go   = (state_r == ST_RESP) && (!out_valid_r || out_ready);

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pixel_r;
  assign out_status      = out_status_r;

  // Source clipping and destination placement for a blit.
  assign x_ext  = {1'b0, in_x_coord};
  assign y_ext  = {1'b0, in_y_coord};
  assign src_ok = (x_ext < source_width_r) && (x_ext < copy_width_r) &&
                  (y_ext < source_height_r) && (y_ext < copy_height_r);

  // Linear destination address from the registered row product.
  assign lin_addr = prod_r + LIN_W'(xd_r);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_width_r    <= DIM_RESET;
      dest_height_r   <= DIM_RESET;
      source_width_r  <= DIM_RESET;
      source_height_r <= DIM_RESET;
      x_offset_r      <= OFFS_RESET;
      y_offset_r      <= OFFS_RESET;
      copy_width_r    <= DIM_RESET;
      copy_height_r   <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEST_WIDTH:    dest_width_r    <= cfg_data;
        CFG_DEST_HEIGHT:   dest_height_r   <= cfg_data;
        CFG_SOURCE_WIDTH:  source_width_r  <= cfg_data;
        CFG_SOURCE_HEIGHT: source_height_r <= cfg_data;
        CFG_X_OFFSET:      x_offset_r      <= cfg_data[7:0];
        CFG_Y_OFFSET:      y_offset_r      <= cfg_data[7:0];
        CFG_COPY_WIDTH:    copy_width_r    <= cfg_data;
        CFG_COPY_HEIGHT:   copy_height_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_ADDR;
      ST_ADDR:   state_nxt = ST_ACCESS;
      ST_ACCESS: begin
        if (!hit_r || cmd_r == CMD_RAW) state_nxt = ST_RESP;
        else                            state_nxt = ST_RDWAIT;
      end
      ST_RDWAIT: begin
        if (cmd_r == CMD_READ) state_nxt = ST_RESP;
        else                   state_nxt = ST_DIV;
      end
      ST_DIV:    state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = ST_RESP;
      ST_RESP:   if (resp_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item datapath: placement, address, blend and result capture.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_r   <= in_cmd;
          color_r <= in_color;
          if (in_cmd == CMD_BLIT) begin
            xd_r <= x_ext + {1'b0, x_offset_r};
            yd_r <= y_ext + {1'b0, y_offset_r};
            ok_r <= src_ok;
          end else begin
            xd_r <= x_ext;
            yd_r <= y_ext;
            ok_r <= 1'b1;
          end
        end
      end
      ST_MUL: begin
        prod_r <= LIN_W'(yd_r) * LIN_W'(dest_width_r);
        ok_r   <= ok_r && (xd_r < dest_width_r) && (yd_r < dest_height_r);
      end
      ST_ADDR: begin
        addr_r <= AW'(lin_addr);
        hit_r  <= ok_r && (32'(lin_addr) < STORE_DEPTH);
      end
      ST_ACCESS: begin
        if (!hit_r) begin
          res_pix_r    <= '0;
          res_status_r <= STAT_SKIPPED;
        end else if (cmd_r == CMD_RAW) begin
          res_pix_r    <= color_r;
          res_status_r <= STAT_WRITTEN;
        end
      end
      ST_RDWAIT: begin
        if (cmd_r == CMD_READ) begin
          res_pix_r    <= ram_rdata;
          res_status_r <= STAT_READ;
        end else begin
          sum_r[0] <= mix_sum(color_r[23:16], ram_rdata[23:16], color_r[31:24]);
          sum_r[1] <= mix_sum(color_r[15:8],  ram_rdata[15:8],  color_r[31:24]);
          sum_r[2] <= mix_sum(color_r[7:0],   ram_rdata[7:0],   color_r[31:24]);
        end
      end
      ST_DIV: begin
        // Channel order swaps: bits 23:16 land in 7:0 and bits 7:0 in 23:16.
        pix_r <= {8'h00, div255(sum_r[2]), div255(sum_r[1]), div255(sum_r[0])};
      end
      ST_WRITE: begin
        res_pix_r    <= pix_r;
        res_status_r <= STAT_WRITTEN;
      end
      default: ;
    endcase
  end

  // Frame RAM access control.
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = color_r;
    case (state_r)
      ST_ACCESS: begin
        ram_en = hit_r;
        ram_we = (cmd_r == CMD_RAW);
      end
      ST_WRITE: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = pix_r;
      end
      default: ;
    endcase
  end

  abps_ram #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (STORE_DEPTH)
  ) u_frame_ram (
    .clk     (clk),
    .en      (ram_en),
    .we      (ram_we),
    .addr    (addr_r),
    .wr_data (ram_wdata),
    .rd_data (ram_rdata)
  );

  // Output register: loads a finished result once the previous beat is gone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_go) begin
      out_pixel_r  <= res_pix_r;
      out_status_r <= res_status_r;
    end
  end

  // A skipped beat always carries a zero pixel.
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_SKIPPED) |-> (out_pixel_r == '0))
    else $error("skipped result carries a nonzero pixel");

  // Only a read command reports read status.
  a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && res_status_r == STAT_READ) |-> (cmd_r == CMD_READ))
    else $error("read status on a non-read command");

  // A blended write-back only happens for an in-range blend or blit.
  a_blend_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> (hit_r && cmd_r != CMD_READ && cmd_r != CMD_RAW))
    else $error("blend write-back without a valid blend target");

  // An accepted item always starts at the row multiply the next cycle.
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_MUL && !in_ready))
    else $error("accepted item did not enter the address path");

endmodule
